FILE: sv/cwd_pkg.sv
// cwd_pkg: shared types, constants and the arctangent table for the
// cosine weighted direction sampler. No dependencies.
`default_nettype none
package cwd_pkg;

   localparam int FracBits     = 16;
   localparam int CordicRounds = 24;
   localparam int SqrtBits     = 16;   // result bits of each square root
   localparam int RadBits      = 31;   // radicand width (value below 2^31)
   localparam int CordW        = 33;   // signed cordic datapath
   localparam int PhaseW       = 32;
   localparam logic [29:0] CordicGain = 30'd652032874;
   localparam logic signed [CordW-1:0] Q15Max = 33'sd32767;

   typedef struct packed {
      logic [FracBits-1:0] angle_fraction;
      logic [FracBits-1:0] radius_fraction;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [14:0]        dir_z;
   } rsp_type;

   function automatic logic signed [CordW-1:0] atan_turn(input logic [4:0] i);
      logic signed [CordW-1:0] v;
      v = '0;
      case (i)
         5'd0:  v = 33'sh20000000;
         5'd1:  v = 33'sh12E4051E;
         5'd2:  v = 33'sh09FB385B;
         5'd3:  v = 33'sh051111D4;
         5'd4:  v = 33'sh028B0D43;
         5'd5:  v = 33'sh0145D7E1;
         5'd6:  v = 33'sh00A2F61E;
         5'd7:  v = 33'sh00517C55;
         5'd8:  v = 33'sh0028BE53;
         5'd9:  v = 33'sh00145F2F;
         5'd10: v = 33'sh000A2F98;
         5'd11: v = 33'sh000517CC;
         5'd12: v = 33'sh00028BE6;
         5'd13: v = 33'sh000145F3;
         5'd14: v = 33'sh0000A2FA;
         5'd15: v = 33'sh0000517D;
         5'd16: v = 33'sh000028BE;
         5'd17: v = 33'sh0000145F;
         5'd18: v = 33'sh00000A30;
         5'd19: v = 33'sh00000518;
         5'd20: v = 33'sh0000028C;
         5'd21: v = 33'sh00000146;
         5'd22: v = 33'sh000000A3;
         5'd23: v = 33'sh00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/cosine_weighted_direction_top.sv
// cosine_weighted_direction_top: sample pipeline around two square roots and
// a cordic rotator. Depends on cwd_pkg, cwd_sqrt and cwd_cordic.
//
// Usage: drive req_data and raise start; a beat is taken at each edge with
// start high. busy is tied low, so a new sample can enter every cycle.
// Stages: the square roots take 16 stages (one result bit each), the
// gain multiply 1, the cordic 24 rounds (one per stage) and the output
// rounding 1. Each result is marked by rsp_valid for exactly one cycle.
// Throughput is one result per cycle.
// The z component comes from the second root and waits in a delay line
// for the cordic. Reset clears only the valid chain; data stages carry
// no reset. The receiver cannot stall, and none is needed: nothing is
// held back anywhere in the pipeline.
`default_nettype none
module cosine_weighted_direction_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire cwd_pkg::req_type   req_data,
   output logic                    rsp_valid,
   output cwd_pkg::rsp_type        rsp_data
);
   localparam int SqLat  = cwd_pkg::SqrtBits;
   localparam int CoLat  = cwd_pkg::CordicRounds + 2;
   localparam int Lat    = SqLat + CoLat;
   localparam int RB     = cwd_pkg::RadBits;
   localparam int F      = cwd_pkg::FracBits;

   logic [RB-1:0] rad_s, rad_z;
   logic [15:0]   root_s, root_z;
   logic [Lat-1:0] vld_ff;
   logic [31:0]   ph_ff [0:SqLat];
   logic [14:0]   z_ff  [0:CoLat];
   logic [F:0]    rz;

   assign busy = 1'b0;
   assign rz    = (F+1)'(1) << F;
   assign rad_s = RB'((64'(req_data.radius_fraction) << 30) >> F);
   assign rad_z = RB'((64'(rz - (F+1)'(req_data.radius_fraction)) << 30) >> F);

   cwd_sqrt u_sqrt_s (.clock(clock), .rad_in(rad_s), .root_out(root_s));
   cwd_sqrt u_sqrt_z (.clock(clock), .rad_in(rad_z), .root_out(root_z));

   // phase rides alongside the root stages
   assign ph_ff[0] = 32'(64'(req_data.angle_fraction) << (32 - F));
   for (genvar k = 0; k < SqLat; k++) begin : g_ph
      always_ff @(posedge clock) ph_ff[k+1] <= ph_ff[k];
   end

   assign z_ff[0] = (root_z > 16'd32767) ? 15'h7FFF : root_z[14:0];
   for (genvar k = 0; k < CoLat; k++) begin : g_z
      always_ff @(posedge clock) z_ff[k+1] <= z_ff[k];
   end

   cwd_cordic u_cordic (
      .clock(clock), .mag_in(root_s), .phase_in(ph_ff[SqLat]),
      .x_out(rsp_data.dir_x), .y_out(rsp_data.dir_y));

   assign rsp_data.dir_z = z_ff[CoLat];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[Lat-2:0], start & ~busy};
   end
   assign rsp_valid = vld_ff[Lat-1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Lat)) else $error("result without beat");
   a_no_lost: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Lat rsp_valid) else $error("beat lost");
   a_zsat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dir_z == 15'h7FFF) |-> $past(root_z >= 16'd32767, CoLat))
      else $error("z saturation mismatch");
endmodule
`default_nettype wire

FILE: sv/cwd_sqrt.sv
// cwd_sqrt: pipelined restoring integer square root, one result bit per
// stage. Uses cwd_pkg for widths.
`default_nettype none
module cwd_sqrt (
   input  wire logic                                  clock,
   input  wire logic [cwd_pkg::RadBits-1:0]           rad_in,
   output logic      [cwd_pkg::SqrtBits-1:0]          root_out
);
   localparam int N  = cwd_pkg::SqrtBits;
   localparam int RW = 2 * N + 2;

   logic [RW-1:0] rem_ff  [0:N];
   logic [RW-1:0] rad_ff  [0:N];
   logic [N-1:0]  root_ff [0:N];

   always_comb begin
      rem_ff[0]  = '0;
      rad_ff[0]  = RW'(rad_in);
      root_ff[0] = '0;
   end

   // one result bit per stage, from the top pair of radicand bits down
   for (genvar k = 0; k < N; k++) begin : g_st
      logic [RW-1:0] rem_in;
      logic [RW-1:0] trial;
      always_comb begin
         rem_in = (rem_ff[k] << 2) | RW'(rad_ff[k][2*N-1 -: 2]);
         trial  = (RW'(root_ff[k]) << 2) | RW'(1);
      end
      always_ff @(posedge clock) begin
         rad_ff[k+1] <= rad_ff[k] << 2;
         if (rem_in >= trial) begin
            rem_ff[k+1]  <= rem_in - trial;
            root_ff[k+1] <= {root_ff[k][N-2:0], 1'b1};
         end else begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= {root_ff[k][N-2:0], 1'b0};
         end
      end
   end

   assign root_out = root_ff[N];
endmodule
`default_nettype wire

FILE: sv/cwd_cordic.sv
// cwd_cordic: rotation-mode cordic, one round per register stage, followed
// by quadrant rotation, rounding and saturation. Uses cwd_pkg.
`default_nettype none
module cwd_cordic (
   input  wire logic                              clock,
   input  wire logic [cwd_pkg::SqrtBits-1:0]      mag_in,
   input  wire logic [cwd_pkg::PhaseW-1:0]        phase_in,
   output logic signed [15:0]                     x_out,
   output logic signed [15:0]                     y_out
);
   localparam int W = cwd_pkg::CordW;
   localparam int R = cwd_pkg::CordicRounds;

   logic [45:0]          prod_ff;
   logic [31:0]          ph0_ff;
   logic signed [W-1:0]  x_ff [0:R];
   logic signed [W-1:0]  y_ff [0:R];
   logic signed [W-1:0]  z_ff [0:R];
   logic [1:0]           q_ff [0:R];
   logic signed [15:0]   xo_ff, yo_ff;

   // gain multiply in its own stage
   always_ff @(posedge clock) begin
      prod_ff <= 46'(mag_in) * 46'(cwd_pkg::CordicGain);
      ph0_ff  <= phase_in;
   end

   always_comb begin
      x_ff[0] = W'(prod_ff[45:16]);
      y_ff[0] = '0;
      z_ff[0] = W'(ph0_ff[29:0]);
      q_ff[0] = ph0_ff[31:30];
   end

   for (genvar i = 0; i < R; i++) begin : g_rnd
      logic signed [W-1:0] dx, dy, at;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         at = cwd_pkg::atan_turn(5'(i));
      end
      always_ff @(posedge clock) begin
         q_ff[i+1] <= q_ff[i];
         if (!z_ff[i][W-1]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - at;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + at;
         end
      end
   end

   function automatic logic signed [15:0] to_q15(input logic signed [W-1:0] v);
      logic signed [W-1:0] r;
      r = (v + W'(1 << 13)) >>> 14;
      if (r > cwd_pkg::Q15Max)       r = cwd_pkg::Q15Max;
      else if (r < -cwd_pkg::Q15Max) r = -cwd_pkg::Q15Max;
      return r[15:0];
   endfunction

   logic signed [W-1:0] cx, cy, xr, yr;
   always_comb begin
      xr = x_ff[R];
      yr = y_ff[R];
      case (q_ff[R])
         2'd0:    begin cx = xr;  cy = yr;  end
         2'd1:    begin cx = -yr; cy = xr;  end
         2'd2:    begin cx = -xr; cy = -yr; end
         default: begin cx = yr;  cy = -xr; end
      endcase
   end

   always_ff @(posedge clock) begin
      xo_ff <= to_q15(cx);
      yo_ff <= to_q15(cy);
   end

   assign x_out = xo_ff;
   assign y_out = yo_ff;
endmodule
`default_nettype wire

FILE: sim/cosine_weighted_direction_top_tb.sv
// cosine_weighted_direction_top_tb: self-checking bench for the cosine weighted
// direction sampler. Depends on cwd_pkg and cosine_weighted_direction_top.
`timescale 1ns / 1ps
module cosine_weighted_direction_top_tb;

   localparam int LATENCY   = 42;
   localparam int WATCHDOG  = 2000;
   localparam int RANDOM_N  = 1650;
   localparam int DIRECTED_N = 14;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   cwd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   cwd_pkg::rsp_type rsp_data;

   cwd_pkg::rsp_type dir_queue[$];
   int      mismatch_count = 0;
   int      beats_sent = 0;
   int      beats_seen = 0;
   int      idle_cycles = 0;
   int      sender_idle_pct = 0;

   cosine_weighted_direction_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] round_q15(input longint v);
      longint r;
      r = (v + (64'sd1 <<< 13)) >>> 14;
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return r[15:0];
   endfunction

   function automatic cwd_pkg::rsp_type predict_direction(input cwd_pkg::req_type rq);
      longint unsigned r2, s, zv;
      longint unsigned phase;
      longint x, y, ang, dx, dy, cx, cy, step;
      logic [1:0] quad;
      cwd_pkg::rsp_type d;
      r2 = rq.radius_fraction;
      s  = int_sqrt((r2 << 30) >> 16);
      zv = int_sqrt(((64'd65536 - r2) << 30) >> 16);
      if (zv > 32767) zv = 32767;
      phase = longint'(rq.angle_fraction) << 16;
      quad = phase[31:30];
      ang = longint'(phase[29:0]);
      x = longint'((s * 64'd652032874) >> 16);
      y = 0;
      for (int i = 0; i < cwd_pkg::CordicRounds; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         step = longint'(cwd_pkg::atan_turn(i[4:0]));
         if (ang >= 0) begin
            x -= dx; y += dy; ang -= step;
         end else begin
            x += dx; y -= dy; ang += step;
         end
      end
      case (quad)
         2'd0: begin cx = x;  cy = y;  end
         2'd1: begin cx = -y; cy = x;  end
         2'd2: begin cx = -x; cy = -y; end
         default: begin cx = y; cy = -x; end
      endcase
      d.dir_x = round_q15(cx);
      d.dir_y = round_q15(cy);
      d.dir_z = zv[14:0];
      return d;
   endfunction

   // directed rows: angle, radius; a fixed expectation for the zero radius row
   logic [15:0] dir_angle [DIRECTED_N] = '{16'h0000, 16'h0000, 16'h4000, 16'h8000,
      16'hC000, 16'hFFFF, 16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'h5555,
      16'hAAAA, 16'h0001, 16'h8001};
   logic [15:0] dir_radius [DIRECTED_N] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000,
      16'hFFFF, 16'h0001, 16'h7FFF};

   task automatic send_sample(input cwd_pkg::req_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      dir_queue.push_back(predict_direction(rq));
      beats_sent++;
      @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         cwd_pkg::rsp_type want;
         beats_seen++;
         if (dir_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = dir_queue.pop_front();
            if (want !== rsp_data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     want.dir_x, want.dir_y, want.dir_z,
                     rsp_data.dir_x, rsp_data.dir_y, rsp_data.dir_z);
            end
         end
      end
   end

   // watchdog on cycles with no beat either way
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      cwd_pkg::req_type rq;
      cwd_pkg::rsp_type fixed;
      int hold;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_N; i++) begin
         rq.angle_fraction = dir_angle[i];
         rq.radius_fraction = dir_radius[i];
         send_sample(rq);
         // zero radius must give straight up
         if (i == 0) begin
            fixed.dir_x = 16'sd0; fixed.dir_y = 16'sd0; fixed.dir_z = 15'd32767;
            if (dir_queue[$] !== fixed) begin
               mismatch_count++;
               $display("zero radius prediction off");
            end
         end
      end
      for (int phase_i = 0; phase_i < 3; phase_i++) begin
         sender_idle_pct = (phase_i == 0) ? 21 : (phase_i == 1) ? 51 : 0;
         for (int n = 0; n < RANDOM_N / 3; n++) begin
            rq.angle_fraction = 16'($urandom);
            case ($urandom_range(7))
               0: rq.radius_fraction = 16'($urandom_range(3));
               1: rq.radius_fraction = 16'(16'hFFFF - $urandom_range(3));
               default: rq.radius_fraction = 16'($urandom);
            endcase
            send_sample(rq);
         end
      end
      start <= 1'b0;
      hold = 0;
      while (dir_queue.size() != 0 && hold < 10 * LATENCY) begin
         @(posedge clock);
         hold++;
      end
      repeat (LATENCY) @(posedge clock);
      if (dir_queue.size() != 0) mismatch_count++;
      $display("sent %0d samples, checked %0d directions, %0d mismatches",
         beats_sent, beats_seen, mismatch_count);
      $display("covered axis angles, zero and full radius, and three idle mixes");
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
